// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, skipped while reset is low.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- rtl/core/kbt_pkg.sv -----
package kbt_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_BIND   = 2'd1;
  localparam logic [1:0] OP_UNBIND = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNBOUND = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] HIT_NONE  = 2'd0;
  localparam logic [1:0] HIT_FUNC  = 2'd1;
  localparam logic [1:0] HIT_MACRO = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_MOVE,
    S_RESP
  } kbt_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key_code;
    logic        target_kind;
    logic [15:0] target_id;
  } kbt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  hit_kind;
    logic [15:0] hit_target;
    logic [8:0]  entries_used;
  } kbt_out_t;

  typedef struct packed {
    logic [15:0] key;
    logic        kind;
    logic [15:0] target;
  } kbt_entry_t;

endpackage

// ----- rtl/core/key_binding_table_core.sv -----
// channel | direction | words                | handshake
// in      | input     | kbt_in_t  in_word_i  | in_valid_i / in_stall_o
// out     | output    | kbt_out_t out_word_o | out_valid_o / out_stall_i
//
// One word at a time: a scan reads one table entry per cycle through the
// single memory read port. A scan stops at the first hit or after the last
// used entry; an unbind hit then moves the last entry into the freed slot.
// An unknown operation goes straight to the response state.
// Reset empties the table at once by clearing the entry count; no clearing pass.
// in_stall_o is high from acceptance until the result enters the output register;
// a stalled result holds that register and the sequencer.
`include "assert_macros.svh"

module key_binding_table_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  kbt_pkg::kbt_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output kbt_pkg::kbt_out_t out_word_o
);
  import kbt_pkg::*;

  kbt_entry_t mem_q [TABLE_DEPTH];

  kbt_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  kbt_in_t          item_q, item_d;
  kbt_out_t         res_q, res_d;
  kbt_out_t         out_word_q;
  logic             out_valid_q;
  kbt_entry_t       rd_data_q;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  kbt_entry_t       wr_data;

  logic             hit;
  logic             last_cmp;
  logic             table_full;
  logic             out_free;
  logic [IDX_W-1:0] next_idx;
  logic [IDX_W-1:0] last_idx;

  assign hit        = rd_data_q.key == item_q.key_code;
  assign last_cmp   = (CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q;
  assign table_full = count_q == CNT_W'(TABLE_DEPTH);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign next_idx   = IDX_W'(cmp_idx_q + IDX_W'(1));
  assign last_idx   = IDX_W'(count_q - CNT_W'(1));

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.kind != OP_LOOKUP && in_word_i.kind != OP_BIND &&
              in_word_i.kind != OP_UNBIND) begin
            state_d = S_RESP;
          end else if (count_q == '0) begin
            state_d = S_MISS;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (item_q.kind == OP_UNBIND) ? S_MOVE : S_RESP;
        end else if (last_cmp) begin
          state_d = S_MISS;
        end
      end
      S_MISS: state_d = S_RESP;
      S_MOVE: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    item_d    = item_q;
    cmp_idx_d = cmp_idx_q;
    count_d   = count_q;
    res_d     = res_q;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = cmp_idx_q;
    wr_data   = rd_data_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_word_i;
          cmp_idx_d = '0;
          res_d     = '{status: ST_OK, hit_kind: HIT_NONE, hit_target: '0,
                        entries_used: '0};
        end
      end
      S_SCAN: begin
        rd_addr   = next_idx;
        cmp_idx_d = next_idx;
        if (hit) begin
          cmp_idx_d = cmp_idx_q;
          case (item_q.kind)
            OP_LOOKUP: begin
              res_d.hit_kind   = rd_data_q.kind ? HIT_MACRO : HIT_FUNC;
              res_d.hit_target = rd_data_q.target;
            end
            OP_BIND: begin
              wr_en   = 1'b1;
              wr_data = '{key: item_q.key_code, kind: item_q.target_kind,
                          target: item_q.target_id};
            end
            OP_UNBIND: rd_addr = last_idx;
            default: ;
          endcase
        end
      end
      S_MISS: begin
        if (item_q.kind == OP_BIND) begin
          if (table_full) begin
            res_d.status = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(count_q);
            wr_data = '{key: item_q.key_code, kind: item_q.target_kind,
                        target: item_q.target_id};
            count_d = count_q + CNT_W'(1);
          end
        end else begin
          res_d.status = ST_UNBOUND;
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        count_d = count_q - CNT_W'(1);
      end
      S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    if (state_q == S_RESP && out_free) begin
      out_word_q <= '{status: res_q.status, hit_kind: res_q.hit_kind,
                      hit_target: res_q.hit_target, entries_used: 9'(count_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(TABLE_DEPTH))
  `ASSERT_NEVER(a_write_state, clk_i, rst_ni, wr_en && (state_q == S_IDLE || state_q == S_RESP))
  `ASSERT_PROP(a_move_shrinks, clk_i, rst_ni, state_q == S_MOVE |=> count_q == $past(count_q) - CNT_W'(1))
  `ASSERT_PROP(a_resp_holds, clk_i, rst_ni, (state_q == S_RESP && out_valid_q && out_stall_i) |=> state_q == S_RESP)

endmodule

// ----- tb/key_binding_table_core_tb.sv -----
`timescale 1ns / 1ps

module key_binding_table_core_tb;
  import kbt_pkg::*;

  localparam logic [1:0]  OP_UNDEF       = 2'd3;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_OPS     = 1400;
  localparam int unsigned KEY_POOL_SIZE  = 40;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  kbt_in_t  in_word_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  kbt_out_t out_word_o;

  kbt_entry_t  bound_tab [TABLE_DEPTH];
  int unsigned bound_cnt = 0;
  kbt_out_t    pending_replies [$];

  bit          quiet         = 1'b0;
  bit          rx_hold_req   = 1'b0;
  bit          mismatch_seen = 1'b0;
  bit          progress;
  int unsigned idle_cycles   = 0;

  key_binding_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic kbt_out_t apply_key_op(input kbt_in_t w);
    kbt_out_t    r;
    int unsigned slot;
    r = '0;
    r.status = ST_OK;
    r.hit_kind = HIT_NONE;
    slot = bound_cnt;
    for (int unsigned i = 0; i < bound_cnt; i++)
      if (slot == bound_cnt && bound_tab[i].key == w.key_code) slot = i;
    case (w.kind)
      OP_LOOKUP: begin
        if (slot < bound_cnt) begin
          r.hit_kind = bound_tab[slot].kind ? HIT_MACRO : HIT_FUNC;
          r.hit_target = bound_tab[slot].target;
        end else begin
          r.status = ST_UNBOUND;
        end
      end
      OP_BIND: begin
        if (slot < bound_cnt) begin
          bound_tab[slot].kind = w.target_kind;
          bound_tab[slot].target = w.target_id;
        end else if (bound_cnt >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          bound_tab[bound_cnt] = '{key: w.key_code, kind: w.target_kind, target: w.target_id};
          bound_cnt++;
        end
      end
      OP_UNBIND: begin
        if (slot < bound_cnt) begin
          bound_tab[slot] = bound_tab[bound_cnt - 1];
          bound_cnt--;
        end else begin
          r.status = ST_UNBOUND;
        end
      end
      default: ;
    endcase
    r.entries_used = 9'(bound_cnt);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  function automatic void check_reply(input kbt_out_t got);
    kbt_out_t want;
    if (pending_replies.size() == 0) begin
      $error("result word %h with nothing outstanding", got);
      mismatch_seen = 1'b1;
    end else begin
      want = pending_replies.pop_front();
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("hit_kind", 16'(want.hit_kind), 16'(got.hit_kind));
      check_field("hit_target", want.hit_target, got.hit_target);
      check_field("entries_used", 16'(want.entries_used), 16'(got.entries_used));
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        pending_replies.push_back(apply_key_op(in_word_i));
        progress = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        check_reply(out_word_o);
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        hold_left = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 35);
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [15:0] key,
                         input logic tk = 1'b0, input logic [15:0] tid = 16'h0);
    kbt_in_t w;
    w.kind = op;
    w.key_code = key;
    w.target_kind = tk;
    w.target_id = tid;
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_op(OP_LOOKUP, 16'h0000);
    send_op(OP_UNBIND, 16'hFFFF);
    send_op(OP_UNDEF, 16'h1234, 1'b1, 16'hFFFF);
    send_op(OP_BIND, 16'h0000, 1'b0, 16'h0000);
    send_op(OP_BIND, 16'hFFFF, 1'b1, 16'hFFFF);
    send_op(OP_LOOKUP, 16'h0000);
    send_op(OP_LOOKUP, 16'hFFFF);
    send_op(OP_BIND, 16'h0000, 1'b1, 16'hA5A5);
    send_op(OP_LOOKUP, 16'h0000);
    send_op(OP_BIND, 16'h5A5A, 1'b0, 16'h5A5A);
    send_op(OP_UNBIND, 16'hFFFF);
    send_op(OP_LOOKUP, 16'h5A5A);
    send_op(OP_LOOKUP, 16'hFFFF);
    send_op(OP_UNBIND, 16'h5A5A);
    send_op(OP_UNDEF, 16'hFFFF, 1'b1, 16'hFFFF);
    send_op(OP_UNBIND, 16'h0000);
    send_op(OP_LOOKUP, 16'h0000);
  endtask

  task automatic test_full_table();
    logic [15:0] base;
    logic [15:0] fill_keys [TABLE_DEPTH + 1];
    logic [15:0] swap;
    int unsigned j;
    base = 16'($urandom_range(65535));
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      fill_keys[i] = base ^ {8'(i), ~8'(i)};
      send_op(OP_BIND, fill_keys[i], 1'($urandom_range(1)), 16'($urandom_range(65535)));
    end
    send_op(OP_LOOKUP, fill_keys[0]);
    send_op(OP_LOOKUP, fill_keys[TABLE_DEPTH - 1]);
    send_op(OP_BIND, base ^ 16'h0000, 1'b1, 16'h1111);
    send_op(OP_BIND, fill_keys[100], 1'b1, 16'hBEEF);
    send_op(OP_LOOKUP, fill_keys[100]);
    send_op(OP_UNDEF, fill_keys[3]);
    send_op(OP_UNBIND, fill_keys[TABLE_DEPTH - 1]);
    send_op(OP_BIND, base ^ 16'h0000, 1'b0, 16'h2222);
    send_op(OP_BIND, base ^ 16'hFFFF, 1'b0, 16'h3333);
    send_op(OP_LOOKUP, base ^ 16'h0000);
    // drain in shuffled order
    fill_keys[TABLE_DEPTH] = base ^ 16'h0000;
    for (int unsigned i = TABLE_DEPTH; i > 0; i--) begin
      j = $urandom_range(i);
      swap = fill_keys[i];
      fill_keys[i] = fill_keys[j];
      fill_keys[j] = swap;
    end
    for (int unsigned i = 0; i <= TABLE_DEPTH; i++) send_op(OP_UNBIND, fill_keys[i]);
  endtask

  task automatic send_pool_op(input logic [15:0] key_pool [KEY_POOL_SIZE]);
    logic [15:0] key;
    logic [1:0]  op;
    int unsigned pick;
    key = ($urandom_range(99) < 92) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)]
                                    : 16'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 38) op = OP_BIND;
    else if (pick < 75) op = OP_LOOKUP;
    else if (pick < 96) op = OP_UNBIND;
    else op = OP_UNDEF;
    send_op(op, key, 1'($urandom_range(1)), 16'($urandom_range(65535)));
  endtask

  task automatic test_output_hold(input logic [15:0] key_pool [KEY_POOL_SIZE]);
    rx_hold_req = 1'b1;
    repeat (8) send_pool_op(key_pool);
  endtask

  task automatic test_random(input logic [15:0] key_pool [KEY_POOL_SIZE]);
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      quiet = (n >= 300 && n < 650);
      send_pool_op(key_pool);
    end
    quiet = 1'b0;
  endtask

  initial begin : run
    logic [15:0] key_pool [KEY_POOL_SIZE];
    for (int unsigned i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = 16'($urandom_range(65535));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_output_hold(key_pool);
    test_random(key_pool);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatch_seen || pending_replies.size() != 0) begin
      $display("CHECK FAILED");
    end else begin
      $display("CHECK OK");
    end
    $finish;
  end

endmodule
